@@ design/delayed_linear_gain_ramp_assert.svh @@
// Assertion macros for the delayed linear gain ramp block.
// Included by the top level; no other dependencies.
`ifndef DELAYED_LINEAR_GAIN_RAMP_ASSERT_SVH
`define DELAYED_LINEAR_GAIN_RAMP_ASSERT_SVH
`ifndef SYNTHESIS
`define DLGR_ASSERT_CLK(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define DLGR_ASSERT(label, prop, msg) \
  `DLGR_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)
`else
`define DLGR_ASSERT_CLK(label, clk, rstn, prop, msg)
`define DLGR_ASSERT(label, prop, msg)
`endif
`endif

@@ design/dlgr_pkg.sv @@
// Shared types, constants and saturation helpers for the gain ramp block.
// No dependencies.
package dlgr_pkg;

  localparam int COUNT_BITS = 20;
  localparam int CNT_W      = COUNT_BITS;
  localparam int STEP_SHIFT = 16;
  localparam int STEP_W     = 32;
  localparam int MUL_B_W    = (CNT_W + 1 > 17) ? CNT_W + 1 : 17;
  localparam int PROD_W     = STEP_W + MUL_B_W;
  localparam int DIV_W      = 32;
  localparam int DIV_CNT_W  = $clog2(DIV_W);
  localparam int CFG_IDX_W  = 1;

  localparam logic OP_SAMPLE   = 1'b0;
  localparam logic OP_RETARGET = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIX_MODE     = 1'b0,
    CFG_DELAYED_STEP = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic               op;
    logic               frame_start;
    logic signed [15:0] sample_in;
    logic signed [15:0] mix_in;
    logic signed [15:0] new_gain;
    logic [19:0]        ramp_len;
    logic [19:0]        delay_len;
  } in_t;

  typedef struct packed {
    logic signed [15:0] sample_out;
    logic               ramping;
  } out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic signed [15:0] sat16_s17(input logic signed [16:0] v);
    if (v > 17'sd32767) return 16'sh7fff;
    if (v < -17'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] sat16_prod(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] pmax;
    logic signed [PROD_W-1:0] pmin;
    pmax = PROD_W'(32767);
    pmin = PROD_W'(-32768);
    if (v > pmax) return 16'sh7fff;
    if (v < pmin) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic logic signed [31:0] sat32_s33(input logic signed [32:0] v);
    if (v > 33'sh0_7fff_ffff) return 32'sh7fff_ffff;
    if (v < -33'sh0_8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

endpackage

@@ design/dlgr_mul.sv @@
// Shared signed multiplier with a registered product.
// Depends on dlgr_pkg.
module dlgr_mul (
  input  logic                                clk_i,
  input  logic signed [dlgr_pkg::STEP_W-1:0]  a_i,
  input  logic signed [dlgr_pkg::MUL_B_W-1:0] b_i,
  output logic signed [dlgr_pkg::PROD_W-1:0]  p_o
);
  import dlgr_pkg::*;

  logic signed [PROD_W-1:0] p_d;
  logic signed [PROD_W-1:0] p_q;

  assign p_d = PROD_W'(a_i) * PROD_W'(b_i);

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

@@ design/dlgr_div.sv @@
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on dlgr_pkg.
module dlgr_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [dlgr_pkg::DIV_W-1:0]      dividend_i,
  input  logic [dlgr_pkg::CNT_W-1:0]      divisor_i,
  output logic [dlgr_pkg::DIV_W-1:0]      quotient_o,
  output dlgr_pkg::div_stat_t             stat_o
);
  import dlgr_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W:0]       rem_q, rem_d;
  logic [DIV_W-1:0]     quo_q, quo_d;
  logic [CNT_W-1:0]     den_q, den_d;
  logic [CNT_W:0]       shifted;
  logic                 fits;

  assign shifted = {rem_q[CNT_W-1:0], quo_q[DIV_W-1]};
  assign fits    = shifted >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(DIV_W - 1);
      rem_d  = '0;
      quo_d  = dividend_i;
      den_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? (shifted - {1'b0, den_q}) : shifted;
      quo_d = {quo_q[DIV_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign quotient_o  = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

@@ design/delayed_linear_gain_ramp.sv @@
// Top level of the delayed linear gain ramp: sequencer, gain state, output register.
// Depends on dlgr_pkg, dlgr_mul, dlgr_div and delayed_linear_gain_ramp_assert.svh.

// Q15 gain stage with a delayed linear ramp. One item is worked on at a time and
// in_stall_o is high until the sequencer is back in idle; the output register
// lets the next item in while a result waits. A sample item passes S_GAIN, S_MUL
// and S_OUT, after S_CG and S_CG2 on a frame start, where the current gain is
// rebuilt through one extra pass of the shared multiplier. A retarget that steps
// at once is done in S_IDLE, a delayed step or an unchanged gain passes S_CG and
// S_CG2, and a ramp also waits in S_DIV on the divider (one step bit per cycle).
`include "delayed_linear_gain_ramp_assert.svh"
module delayed_linear_gain_ramp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dlgr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic                          cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  dlgr_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output dlgr_pkg::out_t                out_data_o
);
  import dlgr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CG,
    S_CG2,
    S_DIV,
    S_GAIN,
    S_MUL,
    S_OUT
  } state_e;

  state_e                    state_q, state_d;
  logic                      mix_mode_q, mix_mode_d;
  logic                      dstep_q, dstep_d;
  logic signed [15:0]        tgt_q, tgt_d;
  logic signed [STEP_W-1:0]  step_q, step_d;
  logic [CNT_W-1:0]          ramp_q, ramp_d;
  logic [CNT_W-1:0]          delay_q, delay_d;
  logic signed [31:0]        rg_q, rg_d;
  in_t                       item_q, item_d;
  logic signed [15:0]        g_q, g_d;
  logic                      neg_q, neg_d;
  logic                      out_valid_q, out_valid_d;
  out_t                      out_q, out_d;

  logic                      accept;
  logic [CNT_W-1:0]          len_in, dly_in, len_it, dly_it;
  logic signed [STEP_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  cg_sh;
  logic signed [15:0]        diff16, cg, change;
  logic [15:0]               mag;
  logic                      div_start;
  logic [DIV_W-1:0]          quotient;
  div_stat_t                 div_stat;
  logic signed [15:0]        y_fill, y_mix, y;
  logic signed [31:0]        rg_sum;

  assign accept = in_valid_i && !in_stall_o;
  assign len_in = CNT_W'(in_data_i.ramp_len);
  assign dly_in = CNT_W'(in_data_i.delay_len);
  assign len_it = CNT_W'(item_q.ramp_len);
  assign dly_it = CNT_W'(item_q.delay_len);

  // one multiplier: remaining-ramp product, or sample times gain
  // (the sample product is held while the result waits in S_OUT)
  always_comb begin
    if (state_q == S_MUL || state_q == S_OUT) begin
      mul_a = STEP_W'(g_q);
      mul_b = MUL_B_W'($signed(item_q.sample_in));
    end else begin
      mul_a = step_q;
      mul_b = MUL_B_W'($signed({1'b0, ramp_q}));
    end
  end

  dlgr_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // current gain = target - sat(step * ramp_left >> 16); zero ramp gives target
  assign cg_sh  = prod >>> STEP_SHIFT;
  assign diff16 = sat16_prod(cg_sh);
  assign cg     = sat16_s17(17'(tgt_q) - 17'(diff16));
  assign change = sat16_s17(17'(item_q.new_gain) - 17'(cg));
  assign mag    = change[15] ? (16'd0 - change) : change;

  dlgr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({mag, 16'h0000}),
    .divisor_i  (len_it),
    .quotient_o (quotient),
    .stat_o     (div_stat)
  );

  assign y_fill = sat16_prod((prod + PROD_W'(16384)) >>> 15);
  assign y_mix  = sat16_s17(17'(item_q.mix_in) + 17'(sat16_prod(prod >>> 15)));
  assign y      = mix_mode_q ? y_mix : y_fill;
  assign rg_sum = sat32_s33(33'(rg_q) + 33'(step_q));

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d     = state_q;
    mix_mode_d  = mix_mode_q;
    dstep_d     = dstep_q;
    tgt_d       = tgt_q;
    step_d      = step_q;
    ramp_d      = ramp_q;
    delay_d     = delay_q;
    rg_d        = rg_q;
    item_d      = item_q;
    g_d         = g_q;
    neg_d       = neg_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    div_start   = 1'b0;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MIX_MODE:     mix_mode_d = cfg_data_i;
        CFG_DELAYED_STEP: dstep_d    = cfg_data_i;
        default:          ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          item_d = in_data_i;
          if (in_data_i.op == OP_RETARGET) begin
            if (len_in == '0 && !(dstep_q && dly_in != '0)) begin
              delay_d = '0;
              ramp_d  = '0;
              step_d  = '0;
              tgt_d   = in_data_i.new_gain;
            end else begin
              state_d = S_CG;
            end
          end else begin
            state_d = in_data_i.frame_start ? S_CG : S_GAIN;
          end
        end
      end
      S_CG: state_d = S_CG2;
      S_CG2: begin
        if (item_q.op == OP_SAMPLE) begin
          rg_d    = {cg, 16'h0000};
          state_d = S_GAIN;
        end else begin
          delay_d = dly_it;
          if (len_it == '0) begin
            ramp_d  = CNT_W'(1);
            step_d  = {change, 16'h0000};
            tgt_d   = item_q.new_gain;
            state_d = S_IDLE;
          end else if (change == '0) begin
            ramp_d  = '0;
            step_d  = '0;
            tgt_d   = item_q.new_gain;
            state_d = S_IDLE;
          end else begin
            neg_d     = change[15];
            div_start = 1'b1;
            state_d   = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          step_d  = neg_q ? (32'sd0 - $signed(quotient)) : $signed(quotient);
          ramp_d  = len_it;
          tgt_d   = item_q.new_gain;
          state_d = S_IDLE;
        end
      end
      S_GAIN: begin
        if (ramp_q == '0 || step_q == '0) begin
          g_d = tgt_q;
        end else if (delay_q != '0) begin
          g_d     = rg_q[31:16];
          delay_d = delay_q - 1'b1;
        end else begin
          g_d    = rg_q[31:16];
          rg_d   = rg_sum;
          ramp_d = ramp_q - 1'b1;
          if (ramp_q == CNT_W'(1)) begin
            step_d = '0;
          end
        end
        state_d = S_MUL;
      end
      S_MUL: state_d = S_OUT;
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.sample_out = y;
          out_d.ramping    = (ramp_q != '0) && (step_q != '0);
          out_valid_d      = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mix_mode_q  <= 1'b0;
      dstep_q     <= 1'b0;
      tgt_q       <= '0;
      step_q      <= '0;
      ramp_q      <= '0;
      delay_q     <= '0;
      rg_q        <= '0;
      item_q      <= '0;
      g_q         <= '0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      mix_mode_q  <= mix_mode_d;
      dstep_q     <= dstep_d;
      tgt_q       <= tgt_d;
      step_q      <= step_d;
      ramp_q      <= ramp_d;
      delay_q     <= delay_d;
      rg_q        <= rg_d;
      item_q      <= item_d;
      g_q         <= g_d;
      neg_q       <= neg_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a finished ramp never leaves a stale step behind
  `DLGR_ASSERT(a_step_clear, (ramp_q == '0) |-> (step_q == '0), "step set with no ramp left")
  `DLGR_ASSERT(a_div_state, div_stat.busy |-> (state_q == S_DIV), "divider busy outside divide")
  `DLGR_ASSERT(a_out_load, (state_q == S_OUT && state_d == S_IDLE) |=> out_valid_q,
               "result beat lost")

endmodule
